// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries concurrent checks (double_hash_table.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dht_pkg.sv =====
// Package of types, constants and handshake structs for the double hashing table.
package dht_pkg;

    localparam int DEF_TABLE_SIZE = 31;
    localparam int DEF_STEP_PRIME = 29;
    localparam int DEF_KEY_BYTES  = 8;

    localparam int KEY_W  = 64;
    localparam int SLOT_W = 5;
    localparam int SUM_W  = 11;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef struct packed {
        t_req              req_type;
        logic [KEY_W-1:0]  key;
        logic [2:0]        rating;
        logic [3:0]        price;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_out_word;

    typedef struct packed {
        logic              occ;
        logic [KEY_W-1:0]  key;
        logic [2:0]        rating;
        logic [3:0]        price;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_HASH,
        S_STEPLD,
        S_STEP,
        S_PROBE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic latch;
        logic load_hash;
        logic load_step;
        logic div_run;
        logic probe;
        logic commit;
        logic set_miss;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic trivial;
        logic div_last;
        logic hit;
        logic exhausted;
        logic out_free;
        logic clear_last;
    } t_sts;

endpackage

// ===== rtl/dht_ctrl.sv =====
// Controller state machine sequencing clear, hashing, probing and result hand-off.
module dht_ctrl
    import dht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = i_sts.trivial ? S_FINISH : S_HASH;
            end
            S_HASH: begin
                if (i_sts.div_last) n_state = S_STEPLD;
            end
            S_STEPLD: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (i_sts.div_last) n_state = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.hit || i_sts.exhausted) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            S_LOAD: begin
                o_cmd.set_miss  = i_sts.trivial;
                o_cmd.load_hash = !i_sts.trivial;
            end
            S_HASH: begin
                o_cmd.div_run = 1'b1;
            end
            S_STEPLD: begin
                o_cmd.load_step = 1'b1;
            end
            S_STEP: begin
                o_cmd.div_run = 1'b1;
            end
            S_PROBE: begin
                o_cmd.probe    = 1'b1;
                o_cmd.commit   = i_sts.hit;
                o_cmd.set_miss = i_sts.exhausted;
            end
            S_FINISH: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/dht_dp.sv =====
// Datapath: key latch, reciprocal remainder units, probe pipeline, slot memory, output register.
module dht_dp
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int STEP_PRIME = DEF_STEP_PRIME,
    parameter int KEY_BYTES  = DEF_KEY_BYTES
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_data,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts
);

    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int PW  = $clog2(STEP_PRIME + 1);
    localparam int PL  = $clog2(STEP_PRIME);
    localparam int HW  = $clog2(255 * KEY_BYTES + 1);
    localparam int DW  = (HW > PW) ? HW : PW;
    localparam int MW  = DW + 2;
    localparam int SN  = DW + IW;
    localparam int SP  = DW + PL;
    localparam int LW  = $clog2(TABLE_SIZE + 2);
    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));
    // Rounded-up reciprocals; exact quotients for every dividend below 2**DW.
    localparam logic [MW-1:0] RECIP_N =
        MW'(((64'd1 << SN) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
    localparam logic [MW-1:0] RECIP_P =
        MW'(((64'd1 << SP) + 64'(STEP_PRIME - 1)) / 64'(STEP_PRIME));

    // Latched request
    t_req             r_req;
    logic [KEY_W-1:0] r_key;
    logic [2:0]       r_rating;
    logic [3:0]       r_price;

    // Remainder units
    logic [DW-1:0]    r_div;
    logic             r_stage;
    logic [DW-1:0]    r_qn;
    logic [DW-1:0]    r_qp;
    logic [IW-1:0]    r_rn;
    logic [PW-1:0]    r_rp;
    logic [DW+MW-1:0] prod_n;
    logic [DW+MW-1:0] prod_p;
    logic [DW-1:0]    rem_n;
    logic [DW-1:0]    rem_p;
    logic [SUM_W-1:0] hash_sum;
    logic [PW-1:0]    step;

    // Probe pipeline
    logic [IW-1:0]    r_idx;
    logic [LW-1:0]    r_left;
    logic             r_pv;
    logic [IW-1:0]    r_pidx;
    logic [IW:0]      idx_sum;
    logic [IW-1:0]    idx_next;
    logic             issue;

    // Memory
    t_entry           mem [TABLE_SIZE];
    t_entry           r_rd;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    t_entry           wr_data;
    logic [IW-1:0]    r_clr;

    logic             match;
    logic             hit;

    t_out_word        r_res;
    t_out_word        r_out;
    logic             r_out_valid;

    always_comb begin
        hash_sum = '0;
        for (int b = 0; b < 8; b++) begin
            hash_sum = hash_sum + SUM_W'(r_key[8*b +: 8]);
        end
    end

    assign step   = PW'(STEP_PRIME) - r_rp;
    assign prod_n = (DW+MW)'(r_div) * (DW+MW)'(RECIP_N);
    assign prod_p = (DW+MW)'(r_div) * (DW+MW)'(RECIP_P);
    assign rem_n  = r_div - r_qn * DW'(TABLE_SIZE);
    assign rem_p  = r_div - r_qp * DW'(STEP_PRIME);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req    <= i_in_data.req_type;
            r_key    <= i_in_data.key & KEY_MASK;
            r_rating <= i_in_data.rating;
            r_price  <= i_in_data.price;
        end
    end

    // Remainder against both moduli at once: the quotients by reciprocal multiplication in
    // the first step, the remainders by multiply and subtract in the second.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_hash || i_cmd.load_step) begin
            r_div   <= i_cmd.load_hash ? DW'(hash_sum) : DW'(step);
            r_stage <= 1'b0;
        end else if (i_cmd.div_run) begin
            r_stage <= 1'b1;
            if (!r_stage) begin
                r_qn <= DW'(prod_n >> SN);
                r_qp <= DW'(prod_p >> SP);
            end else begin
                r_rn <= IW'(rem_n);
                r_rp <= PW'(rem_p);
            end
        end
    end

    assign issue    = i_cmd.probe && (r_left != '0);
    assign idx_sum  = {1'b0, r_idx} + {1'b0, r_rn};
    assign idx_next = (idx_sum >= (IW+1)'(TABLE_SIZE)) ?
                      IW'(idx_sum - (IW+1)'(TABLE_SIZE)) : IW'(idx_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= issue;
        end
    end

    // The home slot is taken from the first pass before the step pass overwrites it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_step) begin
            r_idx  <= r_rn;
            r_left <= LW'(TABLE_SIZE + 1);
        end else if (issue) begin
            r_idx  <= idx_next;
            r_left <= r_left - LW'(1);
        end
        if (issue) begin
            r_pidx <= r_idx;
        end
    end

    assign match = r_rd.occ && (r_rd.key == r_key);
    assign hit   = r_pv && (match || ((r_req == REQ_INSERT) && !r_rd.occ));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pidx;
        wr_data = '0;
        if (i_cmd.clear) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
        end else if (i_cmd.commit) begin
            if (r_req == REQ_INSERT) begin
                wr_en   = !match;
                wr_data = '{occ: 1'b1, key: r_key, rating: r_rating, price: r_price};
            end else if (r_req == REQ_REMOVE) begin
                wr_en   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_miss) begin
            r_res <= '{status: ST_MISS, slot: '0};
        end else if (i_cmd.commit) begin
            if ((r_req == REQ_INSERT) && match) begin
                r_res <= '{status: ST_DUP, slot: '0};
            end else begin
                r_res <= '{status: ST_OK, slot: SLOT_W'(r_pidx)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_sts.trivial    = (r_req == REQ_NONE) || (r_key == '0);
    assign o_sts.div_last   = r_stage;
    assign o_sts.hit        = hit;
    assign o_sts.exhausted  = !r_pv && (r_left == '0);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_sts.clear_last = (r_clr == IW'(TABLE_SIZE - 1));

endmodule

// ===== rtl/double_hash_table.sv =====
// Each accepted word is settled by probe k (1 to TABLE_SIZE+1), or all probes miss; a zero
// key or unused request type skips hashing and probing and returns a miss.
// Two reciprocal remainder passes, then one memory read per probe, make up the work.
// One word at a time: the next is taken after the result is loaded for output, later on stall.
// After reset a clearing pass empties all TABLE_SIZE slots of the memory, input stalled.
// Top level of the double hashing table: controller, datapath and checks.
`include "assert_macros.svh"

module double_hash_table
    import dht_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int STEP_PRIME = DEF_STEP_PRIME,
    parameter int KEY_BYTES  = DEF_KEY_BYTES
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    t_cmd cmd;
    t_sts sts;

    dht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dht_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .STEP_PRIME (STEP_PRIME),
        .KEY_BYTES  (KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken while a word is in flight")
    `ASSERT_IMPLIES(a_commit_xor_miss, i_clk, i_rst_n, cmd.commit, !cmd.set_miss, "hit and miss reported together")
    `ASSERT_IMPLIES(a_slot_zero_on_fail, i_clk, i_rst_n, o_out_valid && (o_out_data.status != ST_OK), o_out_data.slot == '0, "slot nonzero on failed request")
    `ASSERT_IMPLIES(a_no_write_in_clear_and_probe, i_clk, i_rst_n, cmd.clear, !cmd.probe && !cmd.latch, "clearing pass overlaps request work")

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the double hashing table, with its own table predictor.
module tb
    import dht_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int N_SLOTS        = DEF_TABLE_SIZE;
    localparam int STEP_BASE      = DEF_STEP_PRIME;
    localparam logic [KEY_W-1:0] KEY_MASK = (DEF_KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((64'd1 << (8 * DEF_KEY_BYTES)) - 64'd1);
    localparam int N_ITEMS        = 1450;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_DIRECTED     = 22;

    typedef struct packed {
        t_req              req;
        logic [KEY_W-1:0]  key;
        logic [2:0]        rating;
        logic [3:0]        price;
        logic              typed;
        t_status           st;
        logic [SLOT_W-1:0] slot;
    } t_dir_row;

    // Rows marked as typed carry an answer that is plain from the table's state; the
    // rest are checked against the predictor.
    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        '{REQ_LOOKUP, 64'h1,                  3'd0, 4'd0,  1'b1, ST_MISS, 5'd0},
        '{REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 4'd0,  1'b1, ST_MISS, 5'd0},
        '{REQ_INSERT, 64'h0,                  3'd7, 4'd15, 1'b1, ST_MISS, 5'd0},
        '{REQ_NONE,   64'h1,                  3'd7, 4'd15, 1'b1, ST_MISS, 5'd0},
        '{REQ_INSERT, 64'h1,                  3'd0, 4'd0,  1'b1, ST_OK,   5'd1},
        '{REQ_INSERT, 64'h1,                  3'd5, 4'd9,  1'b1, ST_DUP,  5'd0},
        '{REQ_INSERT, 64'h100,                3'd3, 4'd4,  1'b0, ST_OK,   5'd0},
        '{REQ_INSERT, 64'h1_0000,             3'd2, 4'd1,  1'b0, ST_OK,   5'd0},
        '{REQ_LOOKUP, 64'h100,                3'd0, 4'd0,  1'b0, ST_OK,   5'd0},
        '{REQ_REMOVE, 64'h1,                  3'd0, 4'd0,  1'b1, ST_OK,   5'd1},
        '{REQ_LOOKUP, 64'h100,                3'd0, 4'd0,  1'b0, ST_OK,   5'd0},
        '{REQ_LOOKUP, 64'h1,                  3'd0, 4'd0,  1'b1, ST_MISS, 5'd0},
        '{REQ_INSERT, 64'h20,                 3'd1, 4'd8,  1'b0, ST_OK,   5'd0},
        '{REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 4'd15, 1'b0, ST_OK,   5'd0},
        '{REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 4'd0,  1'b0, ST_OK,   5'd0},
        '{REQ_REMOVE, 64'h0,                  3'd0, 4'd0,  1'b1, ST_MISS, 5'd0},
        '{REQ_LOOKUP, 64'h0,                  3'd0, 4'd0,  1'b1, ST_MISS, 5'd0},
        '{REQ_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 4'd0,  1'b1, ST_MISS, 5'd0},
        '{REQ_INSERT, 64'h8000_0000_0000_0000, 3'd5, 4'd15, 1'b0, ST_OK,   5'd0},
        '{REQ_REMOVE, 64'h8000_0000_0000_0000, 3'd0, 4'd0,  1'b0, ST_OK,   5'd0},
        '{REQ_REMOVE, 64'h8000_0000_0000_0000, 3'd0, 4'd0,  1'b0, ST_OK,   5'd0},
        '{REQ_INSERT, 64'h0001_0000_0000_0000, 3'd6, 4'd7,  1'b0, ST_OK,   5'd0}
    };

    logic      i_clk     = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_data;

    // Predicted table contents
    logic [KEY_W-1:0] slot_keys   [N_SLOTS];
    logic [2:0]       slot_rating [N_SLOTS];
    logic [3:0]       slot_price  [N_SLOTS];
    logic             slot_used   [N_SLOTS];

    t_out_word pending_replies[$];

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;
    int n_mismatch = 0;
    int n_sent = 0, n_counted = 0, n_replies = 0, n_holds = 0;
    int n_placed = 0, n_dup = 0, n_full = 0, n_hit = 0, n_miss = 0, n_ignored = 0;
    int idle_cycles = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    double_hash_table uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        for (int i = 0; i < N_SLOTS; i++) begin
            slot_keys[i]   = '0;
            slot_rating[i] = '0;
            slot_price[i]  = '0;
            slot_used[i]   = 1'b0;
        end
    end

    // Works out the answer to one request and applies it to the predicted table.
    function automatic t_out_word hash_table_answer(input t_in_word w);
        logic [KEY_W-1:0] k;
        int unsigned      h, home, step, idx, p, b;
        bit               done;
        t_out_word        r;
        r.status = ST_MISS;
        r.slot   = '0;
        k        = w.key & KEY_MASK;
        if (w.req_type != REQ_NONE && k != '0) begin
            h = 0;
            for (b = 0; b < 8; b++) h += k[8*b +: 8];
            home = h % N_SLOTS;
            step = STEP_BASE - h % STEP_BASE;
            done = 1'b0;
            p    = 0;
            while (!done && p <= N_SLOTS) begin
                idx = (home + p * step) % N_SLOTS;
                if (slot_used[idx] && slot_keys[idx] == k) begin
                    done = 1'b1;
                    if (w.req_type == REQ_INSERT) begin
                        r.status = ST_DUP;
                    end else begin
                        r.status = ST_OK;
                        r.slot   = idx[SLOT_W-1:0];
                        if (w.req_type == REQ_REMOVE) begin
                            slot_keys[idx]   = '0;
                            slot_rating[idx] = '0;
                            slot_price[idx]  = '0;
                            slot_used[idx]   = 1'b0;
                        end
                    end
                end else if (w.req_type == REQ_INSERT && !slot_used[idx]) begin
                    done             = 1'b1;
                    slot_keys[idx]   = k;
                    slot_rating[idx] = w.rating;
                    slot_price[idx]  = w.price;
                    slot_used[idx]   = 1'b1;
                    r.status         = ST_OK;
                    r.slot           = idx[SLOT_W-1:0];
                end
                p++;
            end
        end
        return r;
    endfunction

    // Keys are drawn so that byte sums often coincide: same home and step, or same home
    // with a different step.
    function automatic logic [KEY_W-1:0] make_key();
        logic [KEY_W-1:0] k;
        int               kind, s, a, p0, p1, b;
        k    = '0;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            k = {$urandom, $urandom};
        end else if (kind < 7) begin
            for (b = 0; b < 8; b++)
                if ($urandom_range(0, 2) == 0) k[8*b +: 8] = 8'($urandom_range(1, 3));
        end else begin
            s  = 5 + 31 * $urandom_range(0, 2);
            a  = $urandom_range(0, s);
            p0 = $urandom_range(0, 7);
            p1 = (p0 + $urandom_range(1, 7)) % 8;
            k[8*p0 +: 8] = 8'(a);
            k[8*p1 +: 8] = 8'(s - a);
        end
        return k;
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_ans);
        int        gap;
        t_out_word ans;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        repeat (gap) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        ans = hash_table_answer(w);
        pending_replies.push_back(typed ? typed_ans : ans);
        n_sent++;
        if (w.req_type == REQ_NONE || (w.key & KEY_MASK) == '0) begin
            n_ignored++;
        end else begin
            n_counted++;
            if (w.req_type == REQ_INSERT) begin
                if (ans.status == ST_OK) n_placed++;
                else if (ans.status == ST_DUP) n_dup++;
                else n_full++;
            end else if (ans.status == ST_OK) begin
                n_hit++;
            end else begin
                n_miss++;
            end
        end
    endtask

    // The sender goes quiet first, so the word just taken is not offered again.
    task automatic wait_all_replies();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_round(input bit fill);
        logic [KEY_W-1:0] pool[$];
        int               n_pool, n_ops, j, r;
        t_in_word         w;
        t_out_word        none_ans;
        none_ans = '0;
        n_pool   = fill ? $urandom_range(32, 45) : $urandom_range(4, 40);
        for (j = 0; j < n_pool; j++) pool.push_back(make_key());
        // A filling round inserts the whole pool first, so the table can run out of room.
        if (fill) begin
            for (j = 0; j < n_pool; j++) begin
                w.req_type = REQ_INSERT;
                w.key      = pool[j];
                w.rating   = 3'($urandom_range(0, 7));
                w.price    = 4'($urandom_range(0, 15));
                send_word(w, 1'b0, none_ans);
            end
        end
        n_ops = $urandom_range(20, 80);
        for (j = 0; j < n_ops; j++) begin
            r        = $urandom_range(0, 99);
            w.key    = pool[$urandom_range(0, n_pool - 1)];
            w.rating = 3'($urandom_range(0, 7));
            w.price  = 4'($urandom_range(0, 15));
            if (r < 40) begin
                w.req_type = REQ_INSERT;
            end else if (r < 65) begin
                w.req_type = REQ_REMOVE;
            end else if (r < 92) begin
                w.req_type = REQ_LOOKUP;
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        w.req_type = REQ_NONE;
                        w.key      = {$urandom, $urandom};
                    end
                    1: begin
                        w.req_type = t_req'($urandom_range(0, 2));
                        w.key      = '0;
                    end
                    default: begin
                        w.req_type = REQ_LOOKUP;
                        w.key      = {$urandom, $urandom};
                    end
                endcase
            end
            send_word(w, 1'b0, none_ans);
        end
    endtask

    // Removes every stored key in a shuffled order, leaving the table empty.
    task automatic empty_table();
        logic [KEY_W-1:0] stored[$];
        logic [KEY_W-1:0] tmp;
        int               i, j;
        t_in_word         w;
        t_out_word        none_ans;
        none_ans = '0;
        for (i = 0; i < N_SLOTS; i++)
            if (slot_used[i]) stored.push_back(slot_keys[i]);
        for (i = stored.size() - 1; i > 0; i--) begin
            j         = $urandom_range(0, i);
            tmp       = stored[i];
            stored[i] = stored[j];
            stored[j] = tmp;
        end
        for (i = 0; i < stored.size(); i++) begin
            w.req_type = REQ_REMOVE;
            w.key      = stored[i];
            w.rating   = 3'($urandom_range(0, 7));
            w.price    = 4'($urandom_range(0, 15));
            send_word(w, 1'b0, none_ans);
        end
    endtask

    initial begin : reply_side
        int        hold;
        t_out_word want;
        t_out_word got;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n_holds++;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    out_stall <= 1'b1;
                end
            end
            hold = no_idle ? 0 : $urandom_range(0, 14);
            repeat (hold) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
            end
            @(negedge i_clk);
            out_stall <= 1'b0;
            do @(posedge i_clk); while (out_valid !== 1'b1);
            got = out_data;
            n_replies++;
            if (pending_replies.size() == 0) begin
                $error("unexpected word: status %0d, slot %0d", got.status, got.slot);
                n_mismatch++;
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_mismatch++;
                end
                if (got.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, got.slot);
                    n_mismatch++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("double_hash_table: mismatch");
            $finish;
        end
    end

    initial begin : request_side
        t_in_word  w;
        t_out_word typed_ans;
        int        round;
        repeat (10) @(negedge i_clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++) begin
            w.req_type       = DIRECTED[i].req;
            w.key            = DIRECTED[i].key;
            w.rating         = DIRECTED[i].rating;
            w.price          = DIRECTED[i].price;
            typed_ans.status = DIRECTED[i].st;
            typed_ans.slot   = DIRECTED[i].slot;
            send_word(w, DIRECTED[i].typed, typed_ans);
        end
        wait_all_replies();
        round = 0;
        while (n_counted < N_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            // The receiver backs off for a long stretch while words keep coming.
            if (round == 1 || $urandom_range(0, 11) == 0) hold_req = 1'b1;
            random_round(round == 0 || $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) empty_table();
            if (round % 4 == 3) wait_all_replies();
            round++;
        end
        @(negedge i_clk);
        in_valid <= 1'b0;
        wait_all_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d words sent (%0d ignored), %0d replies; %0d placed, %0d duplicates, %0d full",
                 n_sent, n_ignored, n_replies, n_placed, n_dup, n_full);
        $display("removes and lookups: %0d found, %0d not found; %0d long receiver holds",
                 n_hit, n_miss, n_holds);
        if (n_mismatch == 0) begin
            $display("double_hash_table: match");
        end else begin
            $display("double_hash_table: mismatch");
        end
        $finish;
    end

endmodule
